### src/agtm_pkg.sv
// ----------------------------------------------------------------------------
// agtm_pkg: shared types and constants for the audio gain / tone mixer
// Frame structs, register indexes, and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package agtm_pkg;

    // Sine table and phase accumulator sizes
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;
    localparam int SINE_ADDR_W     = SINE_TABLE_BITS + 1;
    localparam int SINE_W          = 15;

    // Tone step scaling into the phase accumulator width
    localparam int STEP_UP = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
    localparam int STEP_DN = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;

    // Downmix factor 1/sqrt(2) in Q16
    localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;

    // Polynomial for sin(pi/2 * t), Q30
    localparam logic signed [63:0] C_A1 = 64'sd1686629713;
    localparam logic signed [63:0] C_A3 = -64'sd693598668;
    localparam logic signed [63:0] C_A5 = 64'sd85569306;
    localparam logic signed [63:0] C_A7 = -64'sd5026995;
    localparam logic signed [63:0] C_A9 = 64'sd172273;

    // Mono mode code and register reset values
    localparam logic [1:0]  MODE_MONO        = 2'd1;
    localparam logic [1:0]  MODE_RESET       = 2'd2;
    localparam logic [31:0] TONE_STEP_RESET  = 32'd1789570;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CHANNEL_MODE = 3'd0,
        CFG_MIC_GAIN     = 3'd1,
        CFG_TONE_GAIN    = 3'd2,
        CFG_REMOTE_GAIN  = 3'd3,
        CFG_TONE_STEP    = 3'd4
    } t_cfg_idx;

    // One input frame
    typedef struct packed {
        logic signed [15:0] mic_left;
        logic signed [15:0] mic_right;
        logic signed [15:0] remote_left;
        logic signed [15:0] remote_right;
        logic               remote_valid;
    } t_in_item;

    // One mixed output frame
    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
    } t_out_item;

    typedef logic [SINE_W-1:0] t_sine_rom [0:SINE_N];

    // Signed Q30 product, truncated toward zero
    function automatic logic signed [63:0] f_mul_q30(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] r;
        ma = a[63] ? 64'(64'sd0 - a) : 64'(a);
        mb = b[63] ? 64'(64'sd0 - b) : 64'(b);
        r  = (ma * mb) >> 30;
        return (a[63] ^ b[63]) ? (64'sd0 - $signed(r)) : $signed(r);
    endfunction

    // Quarter-wave entry k: round(32767 * P(k/N)), clamped to [0, 32767]
    function automatic logic [SINE_W-1:0] f_quarter_sine(input int unsigned k);
        logic signed [63:0] t;
        logic signed [63:0] t2;
        logic signed [63:0] acc;
        logic signed [63:0] s;
        logic [63:0]        q;
        t   = $signed(64'(k) << (30 - SINE_TABLE_BITS));
        t2  = f_mul_q30(t, t);
        acc = C_A9;
        acc = f_mul_q30(acc, t2) + C_A7;
        acc = f_mul_q30(acc, t2) + C_A5;
        acc = f_mul_q30(acc, t2) + C_A3;
        acc = f_mul_q30(acc, t2) + C_A1;
        s   = f_mul_q30(acc, t);
        if (s <= 0) begin
            q = 64'd0;
        end else begin
            q = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
        end
        return q[SINE_W-1:0];
    endfunction

    // Full table, entries 0..N inclusive
    function automatic t_sine_rom f_build_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k <= SINE_N; k++) begin
            rom[k] = f_quarter_sine(k);
        end
        return rom;
    endfunction

endpackage

### src/agtm_sine_rom.sv
// ----------------------------------------------------------------------------
// agtm_sine_rom: quarter-wave sine ROM
// One read port with registered data; contents built at elaboration.
// ----------------------------------------------------------------------------
module agtm_sine_rom
    import agtm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [SINE_ADDR_W-1:0] i_addr,
    output logic [SINE_W-1:0]      o_data
);

    localparam t_sine_rom SINE_ROM = f_build_sine_rom();

    logic [SINE_W-1:0] r_data;

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

### src/audio_gain_tone_mixer_top.sv
// ----------------------------------------------------------------------------
// audio_gain_tone_mixer_top: mic / remote mixer with an added sine tone
// Applies Q1.15 gains, adds an NCO tone, optional mono downmix of remote.
//
//   channel   direction  handshake                 payload
//   in        sink       i_in_valid / o_in_stall   i_in_data  (t_in_item)
//   out       source     o_out_valid / i_out_stall o_out_data (t_out_item)
//   cfg       sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Three register stages: phase/address, sine ROM read plus downmix, gain mix.
// One frame per cycle while the input is not stalled; a frame passes through
// stage 1, stage 2 and the output register before its output transfer.
// Each stage advances independently, so bubbles are squeezed out while the
// output is stalled; the input stalls only when all three stages are full
// and the output is stalled.
// Synchronous active-low reset clears phase and valids, presets config regs.
// ----------------------------------------------------------------------------
module audio_gain_tone_mixer_top
    import agtm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // Config registers and phase accumulator
    logic [1:0]            r_mode;
    logic [15:0]           r_mic_gain;
    logic [15:0]           r_tone_gain;
    logic [15:0]           r_remote_gain;
    logic [31:0]           r_tone_step;
    logic [PHASE_BITS-1:0] r_phase;

    // Stage 1
    logic                   r_s1_valid;
    t_in_item               r_s1_data;
    logic [SINE_ADDR_W-1:0] r_s1_addr;
    logic                   r_s1_neg;

    // Stage 2
    logic               r_s2_valid;
    logic signed [15:0] r_s2_mic_l;
    logic signed [15:0] r_s2_mic_r;
    logic signed [15:0] r_s2_rem_l;
    logic signed [15:0] r_s2_rem_r;
    logic               r_s2_rem_valid;
    logic               r_s2_neg;
    logic [SINE_W-1:0]  w_sine;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic w_out_en;
    logic w_s2_en;
    logic w_s1_en;
    logic w_in_acc;
    logic w_mono;

    logic [PHASE_BITS-1:0]      w_inc;
    logic [PHASE_BITS-1:0]      n_phase;
    logic [SINE_TABLE_BITS-1:0] w_k;
    logic [1:0]                 w_quad;
    logic [SINE_ADDR_W-1:0]     w_addr;

    logic signed [16:0] w_rsum;
    logic signed [34:0] w_dm_prod;
    logic signed [34:0] w_dm_adj;
    logic signed [15:0] w_dm;

    logic signed [32:0] w_gain_mic;
    logic signed [32:0] w_gain_rem;
    logic signed [32:0] w_mic_l_prod;
    logic signed [32:0] w_mic_r_prod;
    logic signed [32:0] w_rem_l_prod;
    logic signed [32:0] w_rem_r_prod;
    logic [30:0]        w_tone_mag;
    logic [15:0]        w_tone;
    logic [15:0]        w_rem_l_term;
    logic [15:0]        w_rem_r_term;
    logic [15:0]        w_left;
    logic [15:0]        w_right;

    // Stage enables: each stage loads when empty or when its successor moves
    assign w_out_en   = !r_out_valid || !i_out_stall;
    assign w_s2_en    = !r_s2_valid || w_out_en;
    assign w_s1_en    = !r_s1_valid || w_s2_en;
    assign w_in_acc   = i_in_valid && w_s1_en;
    assign o_in_stall = !w_s1_en;
    assign w_mono     = (r_mode == MODE_MONO);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_RESET;
            r_mic_gain    <= '0;
            r_tone_gain   <= '0;
            r_remote_gain <= '0;
            r_tone_step   <= TONE_STEP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CHANNEL_MODE: r_mode        <= i_cfg_data[1:0];
                CFG_MIC_GAIN:     r_mic_gain    <= i_cfg_data[15:0];
                CFG_TONE_GAIN:    r_tone_gain   <= i_cfg_data[15:0];
                CFG_REMOTE_GAIN:  r_remote_gain <= i_cfg_data[15:0];
                CFG_TONE_STEP:    r_tone_step   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Phase advance and table address; the advanced phase serves this frame
    assign w_inc   = PHASE_BITS'((64'(r_tone_step) << STEP_UP) >> STEP_DN);
    assign n_phase = r_phase + w_inc;
    assign w_k     = n_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign w_quad  = n_phase[PHASE_BITS-1 -: 2];
    assign w_addr  = w_quad[0] ? (SINE_ADDR_W'(SINE_N) - {1'b0, w_k}) : {1'b0, w_k};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_in_acc) begin
            r_phase <= n_phase;
        end
    end

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_data <= i_in_data;
            r_s1_addr <= w_addr;
            r_s1_neg  <= w_quad[1];
        end
    end

    // Sine lookup, lands alongside stage 2
    agtm_sine_rom u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (w_s2_en && r_s1_valid),
        .i_addr (r_s1_addr),
        .o_data (w_sine)
    );

    // Mono downmix: (L + R) * 46341 / 65536, truncated toward zero
    assign w_rsum    = 17'(r_s1_data.remote_left) + 17'(r_s1_data.remote_right);
    assign w_dm_prod = 35'(w_rsum) * $signed({18'd0, INV_SQRT2_Q16});
    assign w_dm_adj  = w_dm_prod + (w_dm_prod[34] ? 35'sd65535 : 35'sd0);
    assign w_dm      = w_dm_adj[31:16];

    // Stage 2 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_en && r_s1_valid) begin
            r_s2_mic_l     <= r_s1_data.mic_left;
            r_s2_mic_r     <= r_s1_data.mic_right;
            r_s2_rem_l     <= w_mono ? w_dm : r_s1_data.remote_left;
            r_s2_rem_r     <= r_s1_data.remote_right;
            r_s2_rem_valid <= r_s1_data.remote_valid;
            r_s2_neg       <= r_s1_neg;
        end
    end

    // Gains: floor(x * g / 32768) is an arithmetic shift, wrapped to 16 bits
    assign w_gain_mic   = $signed({17'd0, r_mic_gain});
    assign w_gain_rem   = $signed({17'd0, r_remote_gain});
    assign w_mic_l_prod = 33'(r_s2_mic_l) * w_gain_mic;
    assign w_mic_r_prod = 33'(r_s2_mic_r) * w_gain_mic;
    assign w_rem_l_prod = 33'(r_s2_rem_l) * w_gain_rem;
    assign w_rem_r_prod = 33'(r_s2_rem_r) * w_gain_rem;

    // Tone: magnitude product truncated, sign applied after
    assign w_tone_mag = 31'(r_tone_gain) * 31'(w_sine);
    assign w_tone     = r_s2_neg ? (16'd0 - w_tone_mag[30:15]) : w_tone_mag[30:15];

    assign w_rem_l_term = r_s2_rem_valid ? w_rem_l_prod[30:15] : 16'd0;
    assign w_rem_r_term = r_s2_rem_valid ? w_rem_r_prod[30:15] : 16'd0;

    // Mix; right channel is silent in mono
    assign w_left  = w_mic_l_prod[30:15] + w_tone + w_rem_l_term;
    assign w_right = w_mono ? 16'd0 : (w_mic_r_prod[30:15] + w_tone + w_rem_r_term);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en && r_s2_valid) begin
            r_out_data.out_left  <= $signed(w_left);
            r_out_data.out_right <= $signed(w_right);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    a_mono_right_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && w_mono) |-> (r_out_data.out_right == 16'sd0))
        else $error("right channel not silent in mono mode");

    a_rom_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_addr <= SINE_ADDR_W'(SINE_N)))
        else $error("sine table address out of range");

    a_phase_per_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_cfg_we) |=> (r_phase == $past(r_phase) + $past(w_inc)))
        else $error("phase did not advance by one step on frame transfer");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && !r_s2_valid) |=> !$past(o_in_stall))
        else $error("input stalled while pipeline had a bubble");

endmodule

### tb/audio_gain_tone_mixer_top_tb.sv
// ----------------------------------------------------------------------------
// audio_gain_tone_mixer_top_tb: self-checking bench for the gain / tone mixer
// Drives mic and remote frames through the valid/stall input, predicts every
// mixed frame with an in-bench model of the phase accumulator, sine table,
// gains and mono downmix, and compares each output transfer in order. A short
// table of directed rows runs first, then phases of random frames, each under
// a new register setting written while the pipeline is empty.
// ----------------------------------------------------------------------------
module audio_gain_tone_mixer_top_tb;
    import agtm_pkg::*;

    localparam int  IDLE_PCT       = 36;
    localparam int  SETTLE_CYCLES  = 6;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  RAND_PHASES    = 12;
    localparam int  PHASE_FRAMES   = 150;
    localparam int  QUIET_PHASE    = 3;
    localparam int  HOLD_PHASE     = 6;
    localparam int  TBL_BITS       = 10;
    localparam int  TBL_N          = 1 << TBL_BITS;

    // Sine polynomial coefficients, Q30
    localparam longint POLY_A1 = 1686629713;
    localparam longint POLY_A3 = -693598668;
    localparam longint POLY_A5 = 85569306;
    localparam longint POLY_A7 = -5026995;
    localparam longint POLY_A9 = 172273;
    localparam longint DOWNMIX_Q16 = 46341;

    // Channel modes; anything but mono is stereo
    localparam logic [1:0] MODE_STEREO_ZERO  = 2'd0;
    localparam logic [1:0] MODE_STEREO       = 2'd2;
    localparam logic [1:0] MODE_STEREO_THREE = 2'd3;

    localparam logic [15:0] GAIN_UNITY = 16'd32768;
    localparam logic [15:0] GAIN_MAX   = 16'hFFFF;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_idx   = '0;
    logic [31:0] i_cfg_data  = '0;

    // Bench copy of the block state and registers
    logic [31:0] model_phase;
    logic [1:0]  model_mode;
    logic [15:0] model_mic_gain;
    logic [15:0] model_tone_gain;
    logic [15:0] model_remote_gain;
    logic [31:0] model_step;
    int          sine_quarter [0:TBL_N];

    t_out_item   mix_expect_q [$];
    t_out_item   oldest_mix;
    bit          no_gaps      = 1'b0;
    int          fail_count   = 0;
    int          frames_sent  = 0;
    int          mono_frames  = 0;
    int          mixes_seen   = 0;
    int          cfg_writes   = 0;
    int          quiet_cycles = 0;

    typedef struct {
        bit          is_cfg;
        t_cfg_idx    idx;
        logic [31:0] data;
        t_in_item    frame;
        bit          known;
        t_out_item   want;
    } t_dir_row;

    t_dir_row dir_rows [$];

    audio_gain_tone_mixer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // 12-unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Signed Q30 product, truncated toward zero
    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r  = (ma * mb) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // Keep the low 16 bits as a signed sample
    function automatic longint w16(input longint v);
        logic signed [15:0] s;
        s = v[15:0];
        return s;
    endfunction

    // floor(x * g / 2^15), wrapped
    function automatic longint gain_floor(input longint x, input logic [15:0] g);
        return w16((x * longint'(g)) >>> 15);
    endfunction

    // Advance the phase and mix one frame
    function automatic t_out_item mix_predict(input t_in_item f);
        t_out_item   o;
        logic [11:0] top;
        int          idx;
        longint      sine;
        longint      tone;
        longint      left;
        longint      right;
        longint      dm;
        model_phase = model_phase + model_step;
        top   = model_phase[31:20];
        idx   = top[10] ? TBL_N - int'(top[9:0]) : int'(top[9:0]);
        sine  = sine_quarter[idx];
        if (top[11]) begin
            sine = -sine;
        end
        tone  = w16((longint'(model_tone_gain) * sine) / 32768);
        left  = w16(gain_floor(longint'(f.mic_left), model_mic_gain) + tone);
        right = 0;
        if (model_mode == MODE_MONO) begin
            if (f.remote_valid) begin
                dm   = w16(((longint'(f.remote_left) + longint'(f.remote_right))
                           * DOWNMIX_Q16) / 65536);
                left = w16(left + gain_floor(dm, model_remote_gain));
            end
        end else begin
            right = w16(gain_floor(longint'(f.mic_right), model_mic_gain) + tone);
            if (f.remote_valid) begin
                left  = w16(left + gain_floor(longint'(f.remote_left), model_remote_gain));
                right = w16(right + gain_floor(longint'(f.remote_right),
                                               model_remote_gain));
            end
        end
        o.out_left  = left[15:0];
        o.out_right = right[15:0];
        return o;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return GAIN_UNITY;
            2:       return GAIN_MAX;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Mostly random samples, sometimes the rails
    function automatic logic [15:0] pick_sample();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        end
        return 16'($urandom);
    endfunction

    function automatic void add_cfg(input t_cfg_idx idx, input logic [31:0] data);
        t_dir_row row;
        row = '{is_cfg: 1'b1, idx: idx, data: data, frame: '0, known: 1'b0, want: '0};
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void add_frame(input logic [15:0] ml, input logic [15:0] mr,
                                      input logic [15:0] rl, input logic [15:0] rr,
                                      input bit rv, input bit known,
                                      input logic [15:0] wl, input logic [15:0] wr);
        t_dir_row row;
        row = '{is_cfg: 1'b0, idx: CFG_CHANNEL_MODE, data: '0,
                frame: '{ml, mr, rl, rr, rv}, known: known, want: '{wl, wr}};
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // One input transfer, with random idle cycles ahead of it
    task automatic send_frame(input t_in_item f, input bit known, input t_out_item want);
        t_out_item pred;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pred = mix_predict(f);
        mix_expect_q.insert(mix_expect_q.size(), known ? want : pred);
        frames_sent++;
        if (model_mode == MODE_MONO) begin
            mono_frames++;
        end
    endtask

    // Stop sending and let the pipeline empty
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (mix_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CHANNEL_MODE: model_mode        = data[1:0];
            CFG_MIC_GAIN:     model_mic_gain    = data[15:0];
            CFG_TONE_GAIN:    model_tone_gain   = data[15:0];
            CFG_REMOTE_GAIN:  model_remote_gain = data[15:0];
            CFG_TONE_STEP:    model_step        = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    // Random output stall
    always @(posedge i_clk) begin
        i_out_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Output transfers against the oldest expected mix
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mix_expect_q.size() == 0) begin
                $error("unexpected output transfer: out_left %0d out_right %0d",
                       o_out_data.out_left, o_out_data.out_right);
                fail_count++;
            end else begin
                oldest_mix = mix_expect_q[0];
                mix_expect_q.delete(0);
                mixes_seen++;
                if (o_out_data.out_left !== oldest_mix.out_left) begin
                    $error("out_left: expected %0d, got %0d",
                           oldest_mix.out_left, o_out_data.out_left);
                    fail_count++;
                end
                if (o_out_data.out_right !== oldest_mix.out_right) begin
                    $error("out_right: expected %0d, got %0d",
                           oldest_mix.out_right, o_out_data.out_right);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("audio_gain_tone_mixer_top regression: fail");
            $finish;
        end
    end

    initial begin
        longint   t;
        longint   t2;
        longint   acc;
        longint   s;
        longint   q;
        t_in_item f;

        // Quarter-wave table, entries 0..N
        for (int k = 0; k <= TBL_N; k++) begin
            t   = longint'(k) <<< (30 - TBL_BITS);
            t2  = q30_mul(t, t);
            acc = POLY_A9;
            acc = q30_mul(acc, t2) + POLY_A7;
            acc = q30_mul(acc, t2) + POLY_A5;
            acc = q30_mul(acc, t2) + POLY_A3;
            acc = q30_mul(acc, t2) + POLY_A1;
            s   = q30_mul(acc, t);
            if (s <= 0) begin
                sine_quarter[k] = 0;
            end else begin
                q = (s * 32767 + (longint'(1) <<< 29)) >>> 30;
                sine_quarter[k] = (q > 32767) ? 32767 : int'(q);
            end
        end

        // Register defaults after reset
        model_phase       = '0;
        model_mode        = MODE_STEREO;
        model_mic_gain    = '0;
        model_tone_gain   = '0;
        model_remote_gain = '0;
        model_step        = 32'd1789570;

        // Defaults: all gains zero, so every mix is silent
        add_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'd0, 16'd0);
        add_frame(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'd0, 16'd0);
        add_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd0);
        // Unity mic gain passes samples through
        add_cfg(CFG_MIC_GAIN, 32'(GAIN_UNITY));
        add_frame(16'h7FFF, 16'h8000, 16'd0, 16'd0, 1'b0, 1'b1, 16'h7FFF, 16'h8000);
        add_frame(16'h8000, 16'h7FFF, 16'h1234, 16'h4321, 1'b1, 1'b1, 16'h8000, 16'h7FFF);
        add_frame(16'hFFFF, 16'd1, 16'd0, 16'd0, 1'b0, 1'b1, 16'hFFFF, 16'd1);
        // Mic gain above unity wraps
        add_cfg(CFG_MIC_GAIN, 32'(GAIN_MAX));
        add_frame(16'h8000, 16'h7FFF, 16'd0, 16'd0, 1'b0, 1'b0, '0, '0);
        add_frame(16'd12345, 16'hA460, 16'd0, 16'd0, 1'b0, 1'b0, '0, '0);
        // Remote mixed at unity
        add_cfg(CFG_REMOTE_GAIN, 32'(GAIN_UNITY));
        add_frame(16'd0, 16'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 16'h8000);
        add_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, '0, '0);
        // Mono: downmix of remote, right ignored and zero
        add_cfg(CFG_CHANNEL_MODE, 32'(MODE_MONO));
        add_frame(16'd100, 16'hFF38, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, '0, '0);
        add_frame(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 1'b1, 1'b0, '0, '0);
        add_frame(16'd500, 16'd600, 16'd1000, 16'd1000, 1'b0, 1'b0, '0, '0);
        // Modes 0 and 3 act as stereo
        add_cfg(CFG_CHANNEL_MODE, 32'(MODE_STEREO_ZERO));
        add_frame(16'd300, 16'hFE00, 16'h7000, 16'h9000, 1'b1, 1'b0, '0, '0);
        add_cfg(CFG_CHANNEL_MODE, 32'(MODE_STEREO_THREE));
        add_frame(16'hC000, 16'h4000, 16'h8000, 16'h7FFF, 1'b1, 1'b0, '0, '0);
        // Tone alone, stepping a quarter turn then half a turn, then frozen
        add_cfg(CFG_CHANNEL_MODE, 32'(MODE_STEREO));
        add_cfg(CFG_MIC_GAIN, 32'd0);
        add_cfg(CFG_REMOTE_GAIN, 32'd0);
        add_cfg(CFG_TONE_GAIN, 32'(GAIN_UNITY));
        add_cfg(CFG_TONE_STEP, 32'h4000_0000);
        for (int n = 0; n < 4; n++) begin
            add_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, '0, '0);
        end
        add_cfg(CFG_TONE_STEP, 32'h8000_0000);
        add_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, '0, '0);
        add_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, '0, '0);
        add_cfg(CFG_TONE_STEP, 32'd0);
        add_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, '0, '0);
        // Everything at once, tone gain above unity
        add_cfg(CFG_TONE_STEP, 32'h1234_5678);
        add_cfg(CFG_TONE_GAIN, 32'(GAIN_MAX));
        add_cfg(CFG_MIC_GAIN, 32'(GAIN_UNITY));
        add_cfg(CFG_REMOTE_GAIN, 32'd20000);
        add_frame(16'd20000, 16'hB1E0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, '0, '0);
        add_frame(16'h8000, 16'h7FFF, 16'h0F0F, 16'hF0F0, 1'b1, 1'b0, '0, '0);
        add_frame(16'h5555, 16'hAAAA, 16'd0, 16'd0, 1'b0, 1'b0, '0, '0);

        // Reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                wait_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_frame(dir_rows[i].frame, dir_rows[i].known, dir_rows[i].want);
            end
        end

        // Random phases, one register setting each
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            case ($urandom_range(0, 5))
                0, 1:    write_reg(CFG_CHANNEL_MODE, 32'(MODE_MONO));
                2, 3:    write_reg(CFG_CHANNEL_MODE, 32'(MODE_STEREO));
                4:       write_reg(CFG_CHANNEL_MODE, 32'(MODE_STEREO_ZERO));
                default: write_reg(CFG_CHANNEL_MODE, 32'(MODE_STEREO_THREE));
            endcase
            write_reg(CFG_MIC_GAIN, 32'(pick_gain()));
            write_reg(CFG_TONE_GAIN, 32'(pick_gain()));
            write_reg(CFG_REMOTE_GAIN, 32'(pick_gain()));
            case ($urandom_range(0, 4))
                0:       write_reg(CFG_TONE_STEP, 32'd0);
                1:       write_reg(CFG_TONE_STEP, 32'h8000_0000);
                2:       write_reg(CFG_TONE_STEP, $urandom);
                default: write_reg(CFG_TONE_STEP, $urandom_range(0, 32'h0100_0000));
            endcase
            no_gaps = (ph == QUIET_PHASE);
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                // Sender holds off once until the pipeline has emptied
                if (ph == HOLD_PHASE && n == PHASE_FRAMES / 2) begin
                    wait_drained();
                end
                f.mic_left     = pick_sample();
                f.mic_right    = pick_sample();
                f.remote_left  = pick_sample();
                f.remote_right = pick_sample();
                f.remote_valid = 1'($urandom_range(0, 1));
                send_frame(f, 1'b0, '0);
            end
        end
        no_gaps = 1'b0;

        // Drain and finish
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d frames (%0d mono) across %0d register writes",
                 frames_sent, mono_frames, cfg_writes);
        $display("checked %0d mixed frames, %0d mismatches", mixes_seen, fail_count);
        if (fail_count == 0) begin
            $display("audio_gain_tone_mixer_top regression: pass");
        end else begin
            $display("audio_gain_tone_mixer_top regression: fail");
        end
        $finish;
    end

endmodule
